>>> src/bsc_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
`default_nettype none

package bsc_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One classified job: up to four result words produced by one input word.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            has_data;
		logic            bad;
		logic            last;
	} bsc_job_t;

	// Map a six-bit value to its alphabet character.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + (w - 8'd26);
		end else if (v < 6'd62) begin
			return 8'h30 + (w - 8'd52);
		end else if (v == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

	// Map a character to {valid, value}; valid is low outside the alphabet.
	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c inside {[8'h41:8'h5a]}) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end else if (c inside {[8'h61:8'h7a]}) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end else if (c == 8'h2b) begin
			return {1'b1, 6'd62};
		end else if (c == 8'h2f) begin
			return {1'b1, 6'd63};
		end else begin
			return {1'b0, d[5:0]};
		end
	endfunction

endpackage

`default_nettype wire

>>> src/bsc_if.sv
// Stream interfaces for input words and result words of the base64 codec.
`default_nettype none

interface bsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface bsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_data;
	logic       out_last;
	logic       bad_length;

	modport source (output valid, output out_byte, output has_data, output out_last,
		output bad_length, input ready);
	modport sink   (input valid, input out_byte, input has_data, input out_last,
		input bad_length, output ready);
endinterface

`default_nettype wire

>>> src/base64_stream_codec.sv
// Top level of the streaming base64 encoder and decoder.
`default_nettype none

// Base64 (standard alphabet, '=' padding) codec for byte streams. The mode
// register selects encode (0) or decode (1); writing it clears any partial
// group. Input words are taken one per cycle while the job queue has room,
// each producing zero to four result words. The result side emits one word
// per cycle while the receiver is ready, so encoding is limited by the
// result side, and a message ending in a padded group still yields four
// result words for its final word; decoding takes one input word per
// cycle. The one-word-per-cycle output register sets that limit. The first
// result passes through the job queue and then the output register.
// In decode, the first character outside the alphabet ends the text; a
// leftover of one character yields a bare marker word with bad_length set.
module base64_stream_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  mode_we,
	input  wire logic  mode_wdata,
	bsc_in_if.sink     items,
	bsc_out_if.source  results
);

	logic              push;
	logic              full;
	logic              pop;
	logic              head_valid;
	bsc_pkg::bsc_job_t push_job;
	bsc_pkg::bsc_job_t head_job;

	bsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.items      (items),
		.full       (full),
		.push       (push),
		.job        (push_job)
	);

	bsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	bsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire

>>> src/bsc_front.sv
// Front end: accepts words, tracks group state and classifies them into jobs.
`default_nettype none

module bsc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mode_we,
	input  wire logic          mode_wdata,
	bsc_in_if.sink             items,
	input  wire logic          full,
	output logic               push,
	output bsc_pkg::bsc_job_t  job
);

	logic        mode_q;
	logic [23:0] gb_q;
	logic [1:0]  cnt_q;
	logic        ended_q;

	logic [23:0] gb_d;
	logic [1:0]  cnt_d;
	logic        ended_d;
	logic        job_push;
	logic        accept;

	logic [23:0] enc_bits;
	logic [23:0] pad_bits;
	logic [6:0]  dv;
	logic [23:0] dec_bits;
	logic [1:0]  dec_cnt;
	logic        full_grp;

	assign items.ready = !full;
	assign accept      = items.valid && !full;
	assign push        = accept && job_push;

	// Classify the current word and compute the next group state
	always_comb begin
		job      = '0;
		job_push = 1'b0;
		gb_d     = gb_q;
		cnt_d    = cnt_q;
		ended_d  = ended_q;
		enc_bits = {gb_q[15:0], items.in_byte};
		pad_bits = '0;
		dv       = bsc_pkg::dec_value(items.in_byte);
		dec_bits = gb_q;
		dec_cnt  = cnt_q;
		full_grp = 1'b0;

		if (mode_q == bsc_pkg::MODE_ENCODE) begin
			cnt_d = cnt_q + 2'd1;
			job.has_data = 1'b1;
			job.last_idx = 2'd3;
			if (cnt_q == 2'd2) begin
				// complete group: four characters
				job.data[0] = bsc_pkg::enc_char(enc_bits[23:18]);
				job.data[1] = bsc_pkg::enc_char(enc_bits[17:12]);
				job.data[2] = bsc_pkg::enc_char(enc_bits[11:6]);
				job.data[3] = bsc_pkg::enc_char(enc_bits[5:0]);
				job.last    = items.is_last;
				job_push    = 1'b1;
				gb_d        = '0;
				cnt_d       = 2'd0;
			end else begin
				gb_d = enc_bits;
				if (items.is_last) begin
					// partial group: pad out to four characters
					job_push = 1'b1;
					job.last = 1'b1;
					if (cnt_q == 2'd0) begin
						pad_bits    = {items.in_byte, 16'h0000};
						job.data[2] = bsc_pkg::PAD_CHAR;
					end else begin
						pad_bits    = {gb_q[7:0], items.in_byte, 8'h00};
						job.data[2] = bsc_pkg::enc_char(pad_bits[11:6]);
					end
					job.data[0] = bsc_pkg::enc_char(pad_bits[23:18]);
					job.data[1] = bsc_pkg::enc_char(pad_bits[17:12]);
					job.data[3] = bsc_pkg::PAD_CHAR;
				end
			end
		end else begin
			job.has_data = 1'b1;
			if (!ended_q) begin
				if (!dv[6]) begin
					ended_d = 1'b1;
				end else begin
					dec_bits = {gb_q[17:0], dv[5:0]};
					dec_cnt  = cnt_q + 2'd1;
					if (dec_cnt == 2'd0) begin
						// four characters make three bytes
						job.data[0]  = dec_bits[23:16];
						job.data[1]  = dec_bits[15:8];
						job.data[2]  = dec_bits[7:0];
						job.last_idx = 2'd2;
						job_push     = 1'b1;
						full_grp     = 1'b1;
						dec_bits     = '0;
					end
				end
			end
			gb_d  = dec_bits;
			cnt_d = dec_cnt;
			if (items.is_last) begin
				// flush the leftover of the text
				job_push = 1'b1;
				job.last = 1'b1;
				case (dec_cnt)
					2'd0: begin
						if (!full_grp) begin
							job.has_data = 1'b0;
							job.last_idx = 2'd0;
						end
					end
					2'd1: begin
						job.has_data = 1'b0;
						job.bad      = 1'b1;
						job.last_idx = 2'd0;
					end
					2'd2: begin
						job.data[0]  = dec_bits[11:4];
						job.last_idx = 2'd0;
					end
					2'd3: begin
						job.data[0]  = dec_bits[17:10];
						job.data[1]  = dec_bits[9:2];
						job.last_idx = 2'd1;
					end
					default: begin
						job.last_idx = 2'd0;
					end
				endcase
			end
		end

		if (items.is_last) begin
			gb_d    = '0;
			cnt_d   = 2'd0;
			ended_d = 1'b0;
		end
	end

	// Hold mode and group state; a mode write clears the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bsc_pkg::MODE_ENCODE;
			gb_q    <= '0;
			cnt_q   <= 2'd0;
			ended_q <= 1'b0;
		end else if (mode_we) begin
			mode_q  <= mode_wdata;
			gb_q    <= '0;
			cnt_q   <= 2'd0;
			ended_q <= 1'b0;
		end else if (accept) begin
			gb_q    <= gb_d;
			cnt_q   <= cnt_d;
			ended_q <= ended_d;
		end
	end

endmodule

`default_nettype wire

>>> src/bsc_queue.sv
// Job queue between the front end and the back end.
`default_nettype none

module bsc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bsc_pkg::bsc_job_t  push_job,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output bsc_pkg::bsc_job_t       head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	bsc_pkg::bsc_job_t slots_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("job popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue fill count out of range");

endmodule

`default_nettype wire

>>> src/bsc_back.sv
// Back end: expands queued jobs into result words, one per cycle while the receiver is ready.
`default_nettype none

module bsc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire bsc_pkg::bsc_job_t  head_job,
	output logic                    pop,
	bsc_out_if.source               results
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_data_q;
	logic       out_last_q;
	logic       bad_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!out_valid_q || results.ready);
	assign at_end = (idx_q == head_job.last_idx);
	assign pop    = load && at_end;

	assign results.valid      = out_valid_q;
	assign results.out_byte   = out_byte_q;
	assign results.has_data   = has_data_q;
	assign results.out_last   = out_last_q;
	assign results.bad_length = bad_q;

	// Advance through the head job and track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the next result word
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_job.has_data ? head_job.data[idx_q] : 8'h00;
			has_data_q <= head_job.has_data;
			out_last_q <= head_job.last && at_end;
			bad_q      <= head_job.bad;
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head_job.last_idx)
		else $error("result index past end of job");

endmodule

`default_nettype wire

>>> sim/bsc_stream_predictor.sv
// Result predictor and comparator for the base64 stream codec, fed by the channels it watches.
`default_nettype none

module bsc_stream_predictor (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic mode_we,
	input  wire logic mode_wdata,
	bsc_in_if         items,
	bsc_out_if        results,
	output int        mismatches,
	output int        pending,
	output int        words_in,
	output int        words_out
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       out_last;
		logic       bad_length;
	} b64_result_t;

	b64_result_t expected_q[$];

	logic        cur_mode;
	logic [23:0] grp_bits;
	logic [1:0]  grp_cnt;
	logic        text_done;

	string alpha_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		return alpha_set[int'(v)];
	endfunction

	// Value of a text character, or -1 outside the alphabet.
	function automatic int char_sextet(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return int'(c) - 'h41;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			return int'(c) - 'h61 + 26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			return int'(c) - 'h30 + 52;
		end else if (c == 8'h2b) begin
			return 62;
		end else if (c == 8'h2f) begin
			return 63;
		end
		return -1;
	endfunction

	task automatic queue_result(input logic [7:0] b, input logic has, input logic lst,
		input logic bad);
		b64_result_t r;
		r.out_byte   = b;
		r.has_data   = has;
		r.out_last   = lst;
		r.bad_length = bad;
		expected_q.push_back(r);
	endtask

	task automatic clear_group();
		grp_bits  = '0;
		grp_cnt   = '0;
		text_done = 1'b0;
	endtask

	// Work out the result words that one accepted input word causes.
	task automatic predict_word(input logic [7:0] b, input logic lst);
		int          n;
		int          v;
		logic [23:0] pad_bits;
		n = 0;
		if (cur_mode == bsc_pkg::MODE_ENCODE) begin
			grp_bits = {grp_bits[15:0], b};
			grp_cnt  = grp_cnt + 2'd1;
			if (grp_cnt == 2'd3) begin
				queue_result(sextet_char(grp_bits[23:18]), 1'b1, 1'b0, 1'b0);
				queue_result(sextet_char(grp_bits[17:12]), 1'b1, 1'b0, 1'b0);
				queue_result(sextet_char(grp_bits[11:6]), 1'b1, 1'b0, 1'b0);
				queue_result(sextet_char(grp_bits[5:0]), 1'b1, lst, 1'b0);
				grp_bits = '0;
				grp_cnt  = '0;
			end else if (lst) begin
				if (grp_cnt == 2'd1) begin
					pad_bits = {grp_bits[7:0], 16'h0000};
					queue_result(sextet_char(pad_bits[23:18]), 1'b1, 1'b0, 1'b0);
					queue_result(sextet_char(pad_bits[17:12]), 1'b1, 1'b0, 1'b0);
					queue_result(bsc_pkg::PAD_CHAR, 1'b1, 1'b0, 1'b0);
				end else begin
					pad_bits = {grp_bits[15:0], 8'h00};
					queue_result(sextet_char(pad_bits[23:18]), 1'b1, 1'b0, 1'b0);
					queue_result(sextet_char(pad_bits[17:12]), 1'b1, 1'b0, 1'b0);
					queue_result(sextet_char(pad_bits[11:6]), 1'b1, 1'b0, 1'b0);
				end
				queue_result(bsc_pkg::PAD_CHAR, 1'b1, 1'b1, 1'b0);
			end
		end else begin
			// Gather characters until the first one outside the alphabet.
			if (!text_done) begin
				v = char_sextet(b);
				if (v < 0) begin
					text_done = 1'b1;
				end else begin
					grp_bits = {grp_bits[17:0], v[5:0]};
					grp_cnt  = grp_cnt + 2'd1;
					if (grp_cnt == 2'd0) begin
						queue_result(grp_bits[23:16], 1'b1, 1'b0, 1'b0);
						queue_result(grp_bits[15:8], 1'b1, 1'b0, 1'b0);
						queue_result(grp_bits[7:0], 1'b1, 1'b0, 1'b0);
						n = 3;
						grp_bits = '0;
					end
				end
			end
			// Flush the leftover on the final word.
			if (lst) begin
				case (grp_cnt)
					2'd0: begin
						if (n > 0) begin
							expected_q[expected_q.size() - 1].out_last = 1'b1;
						end else begin
							queue_result(8'h00, 1'b0, 1'b1, 1'b0);
						end
					end
					2'd1: begin
						queue_result(8'h00, 1'b0, 1'b1, 1'b1);
					end
					2'd2: begin
						queue_result(grp_bits[11:4], 1'b1, 1'b1, 1'b0);
					end
					default: begin
						queue_result(grp_bits[17:10], 1'b1, 1'b0, 1'b0);
						queue_result(grp_bits[9:2], 1'b1, 1'b1, 1'b0);
					end
				endcase
			end
		end
		if (lst) begin
			clear_group();
		end
	endtask

	// Compare one accepted result word with the oldest expectation.
	task automatic compare_result();
		b64_result_t want;
		if (expected_q.size() == 0) begin
			$error("result word with nothing expected: out_byte %h has_data %b out_last %b",
				results.out_byte, results.has_data, results.out_last);
			mismatches++;
		end else begin
			want = expected_q.pop_front();
			if (results.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, results.out_byte);
				mismatches++;
			end
			if (results.has_data !== want.has_data) begin
				$error("has_data: expected %b, actual %b", want.has_data, results.has_data);
				mismatches++;
			end
			if (results.out_last !== want.out_last) begin
				$error("out_last: expected %b, actual %b", want.out_last, results.out_last);
				mismatches++;
			end
			if (results.bad_length !== want.bad_length) begin
				$error("bad_length: expected %b, actual %b", want.bad_length,
					results.bad_length);
				mismatches++;
			end
		end
	endtask

	// Track mode writes, predict on accepted input words, check accepted result words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = bsc_pkg::MODE_ENCODE;
			clear_group();
			expected_q.delete();
			mismatches = 0;
			words_in   = 0;
			words_out  = 0;
			pending   <= 0;
		end else begin
			if (mode_we) begin
				cur_mode = mode_wdata;
				clear_group();
			end
			if (items.valid && items.ready) begin
				predict_word(items.in_byte, items.is_last);
				words_in++;
			end
			if (results.valid && results.ready) begin
				compare_result();
				words_out++;
			end
			pending <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_base64_stream_codec.sv
// Stimulus, output flow control and verdict for the base64 stream codec.
`default_nettype none

module tb_base64_stream_codec;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 4;
	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 80;
	localparam int SEGMENT_WORDS = 45;

	logic clk        = 1'b0;
	logic arst_n     = 1'b0;
	logic mode_we    = 1'b0;
	logic mode_wdata = 1'b0;

	int send_idle = 19;
	int recv_idle = 80;
	int hold_seq  = 0;

	int mismatches;
	int pending;
	int words_in;
	int words_out;

	bsc_in_if  items ();
	bsc_out_if results ();

	always #HALF_PERIOD clk = ~clk;

	base64_stream_codec dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.items      (items),
		.results    (results)
	);

	bsc_stream_predictor u_predict (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.items      (items),
		.results    (results),
		.mismatches (mismatches),
		.pending    (pending),
		.words_in   (words_in),
		.words_out  (words_out)
	);

	// Offer one word after random idle cycles; return once it is accepted.
	task automatic push_word(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid   <= 1'b1;
		items.in_byte <= b;
		items.is_last <= lst;
		do @(posedge clk); while (!items.ready);
	endtask

	// Drop valid and wait until every expected word has come out.
	task automatic drain();
		items.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		mode_we    <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we    <= 1'b0;
	endtask

	task automatic push_text(input string s, input logic end_msg);
		for (int i = 0; i < s.len(); i++) begin
			push_word(s[i], end_msg && (i == s.len() - 1));
		end
	endtask

	task automatic push_enc_msg(input int len, inout int count);
		for (int i = 0; i < len; i++) begin
			push_word(8'($urandom_range(255)), i == len - 1);
			count++;
		end
	endtask

	// Mostly well-formed text, sometimes ended early by a pad or junk character.
	task automatic push_dec_msg(input int len, inout int count);
		int         stop_at;
		logic [7:0] c;
		stop_at = ($urandom_range(2) == 0) ? $urandom_range(len - 1) : len;
		for (int i = 0; i < len; i++) begin
			if (i < stop_at) begin
				if ($urandom_range(99) < 5) begin
					c = 8'($urandom_range(255));
				end else begin
					c = bsc_pkg::enc_char(6'($urandom_range(63)));
				end
			end else if (i == stop_at) begin
				c = $urandom_range(1) ? bsc_pkg::PAD_CHAR : 8'($urandom_range(255));
			end else begin
				c = 8'($urandom_range(255));
			end
			push_word(c, i == len - 1);
			count++;
		end
	endtask

	task automatic run_segment(input logic m, input int target);
		int count;
		count = 0;
		write_mode(m);
		while (count < target) begin
			if (m == bsc_pkg::MODE_ENCODE) begin
				push_enc_msg($urandom_range(1, 12), count);
			end else begin
				push_dec_msg($urandom_range(1, 16), count);
			end
		end
	endtask

	// Drive output ready: random stalls, or a long hold-off when requested.
	initial begin : rx_ready
		int hold_seen;
		hold_seen = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				results.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// End the run when no word moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready) || mode_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_base64_stream_codec failed");
		$finish;
	end

	initial begin : stimulus
		int count;
		items.valid   <= 1'b0;
		items.in_byte <= 8'h00;
		items.is_last <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Encode: full group, one-byte and two-byte padding, group ending the message.
		write_mode(bsc_pkg::MODE_ENCODE);
		push_word(8'h00, 1'b0);
		push_word(8'hff, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'hff, 1'b1);
		push_word(8'h01, 1'b0);
		push_word(8'hfe, 1'b1);
		push_word(8'h5a, 1'b0);
		push_word(8'ha5, 1'b0);
		push_word(8'h3c, 1'b1);

		// Decode: full group at the end, leftovers of two and three, a lone character,
		// a bare end, text ended by a pad with a character ignored after it.
		write_mode(bsc_pkg::MODE_DECODE);
		push_text("Az09", 1'b1);
		push_text("QR", 1'b1);
		push_text("QUI", 1'b1);
		push_text("Q", 1'b1);
		push_text("=", 1'b1);
		push_text("/+=x", 1'b1);
		push_word(8'hff, 1'b1);
		// Leave a partial group behind; the mode write must clear it.
		push_text("QU", 1'b0);

		// Sender idles lightly, receiver heavily.
		run_segment(bsc_pkg::MODE_ENCODE, SEGMENT_WORDS);
		run_segment(bsc_pkg::MODE_DECODE, SEGMENT_WORDS);

		// Swap the idle pattern.
		drain();
		send_idle = 80;
		recv_idle = 19;
		run_segment(bsc_pkg::MODE_DECODE, SEGMENT_WORDS);
		run_segment(bsc_pkg::MODE_ENCODE, SEGMENT_WORDS);

		// No idling; hold off the receiver while a long message fills the block.
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_mode(bsc_pkg::MODE_ENCODE);
		hold_seq <= hold_seq + 1;
		count = 0;
		push_enc_msg(30, count);
		run_segment(bsc_pkg::MODE_ENCODE, SEGMENT_WORDS - 30);
		run_segment(bsc_pkg::MODE_DECODE, SEGMENT_WORDS);

		drain();
		$display("Run covered %0d input words and %0d result words in both modes,", words_in,
			words_out);
		$display("under light, heavy and no idling and one long output hold-off.");
		if (mismatches == 0 && pending == 0) begin
			$display("tb_base64_stream_codec passed");
		end else begin
			$display("tb_base64_stream_codec failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> base64_stream_codec.f
src/bsc_pkg.sv
src/bsc_if.sv
src/bsc_front.sv
src/bsc_queue.sv
src/bsc_back.sv
src/base64_stream_codec.sv
sim/bsc_stream_predictor.sv
sim/tb_base64_stream_codec.sv
